### sv/multi_pattern_dfa_matcher_core_defines.svh
// Assertion helpers shared by the matcher modules.
`ifndef MULTI_PATTERN_DFA_MATCHER_CORE_DEFINES_SVH
`define MULTI_PATTERN_DFA_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MPDFA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MPDFA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mpdfa_pkg.sv
`default_nettype none

package mpdfa_pkg;

    localparam int BYTE_W        = 8;
    localparam int BYTE_SYMBOLS  = 256;
    localparam int STATE_FIELD_W = 10;
    localparam int COUNT_FIELD_W = 5;
    localparam int LIST_FIELD_W  = 12;
    localparam int ID_FIELD_W    = 16;
    localparam int POS_FIELD_W   = 16;
    localparam int RED_CNT_W     = 4;

    typedef enum logic [1:0] {
        ACT_SCAN     = 2'd0,
        ACT_WR_TRANS = 2'd1,
        ACT_WR_DESC  = 2'd2,
        ACT_WR_LIST  = 2'd3
    } action_t;

    typedef struct packed {
        action_t                  action;
        logic [BYTE_W-1:0]        byte_value;
        logic                     first_byte;
        logic [STATE_FIELD_W-1:0] state_index;
        logic [STATE_FIELD_W-1:0] target_state;
        logic [COUNT_FIELD_W-1:0] match_count;
        logic [LIST_FIELD_W-1:0]  list_start;
        logic [LIST_FIELD_W-1:0]  list_index;
        logic [ID_FIELD_W-1:0]    pat_id;
    } in_item_t;

    typedef struct packed {
        logic [ID_FIELD_W-1:0]  found_pattern;
        logic [POS_FIELD_W-1:0] byte_position;
        logic                   last_match;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] count;
        logic [LIST_FIELD_W-1:0]  start;
    } desc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_PREP,
        ST_REDUCE,
        ST_READ,
        ST_EMIT,
        ST_LWRITE
    } ctrl_state_t;

    typedef struct packed {
        logic                 accept;
        logic                 desc_rd;
        logic                 prep;
        logic                 red_en;
        logic [RED_CNT_W-1:0] red_idx;
        logic                 list_rd;
        logic                 emit;
        logic                 list_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic rem_last;
        logic out_free;
    } dp_status_t;

    // Number of shift-and-subtract steps that bring a list index field value
    // below the list depth. Zero when every field value is already in range.
    function automatic int red_steps(input int depth);
        longint shifted;
        int     n;
        n = 0;
        for (int j = 0; j <= LIST_FIELD_W; j++) begin
            shifted = longint'(depth) << j;
            if (shifted < (longint'(1) << LIST_FIELD_W)) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### sv/mpdfa_ctrl.sv
`default_nettype none
`include "multi_pattern_dfa_matcher_core_defines.svh"

module mpdfa_ctrl #(
    parameter int LIST_DEPTH = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  mpdfa_pkg::action_t     action,
    input  mpdfa_pkg::dp_status_t  sts,
    output logic                   item_stall,
    output mpdfa_pkg::dp_cmd_t     cmd
);
    import mpdfa_pkg::*;

    localparam int RED_STEPS = red_steps(LIST_DEPTH);
    localparam logic [RED_CNT_W-1:0] RED_TOP =
        RED_CNT_W'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);

    ctrl_state_t          state_reg, state_next;
    logic [RED_CNT_W-1:0] red_cnt_reg, red_cnt_next;
    logic                 lw_mode_reg, lw_mode_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            red_cnt_reg <= '0;
            lw_mode_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            red_cnt_reg <= red_cnt_next;
            lw_mode_reg <= lw_mode_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        red_cnt_next = red_cnt_reg;
        lw_mode_next = lw_mode_reg;
        cmd          = '0;
        item_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                cmd.accept = item_valid;
                if (item_valid) begin
                    case (action)
                        ACT_SCAN:
                        begin
                            lw_mode_next = 1'b0;
                            state_next   = ST_DESC;
                        end
                        ACT_WR_LIST:
                        begin
                            lw_mode_next = 1'b1;
                            red_cnt_next = RED_TOP;
                            state_next   = (RED_STEPS > 0) ? ST_REDUCE : ST_LWRITE;
                        end
                        default:
                        begin
                            // Table and descriptor writes finish in the accept cycle.
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DESC:
            begin
                cmd.desc_rd = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep     = 1'b1;
                red_cnt_next = RED_TOP;
                if (sts.cnt_zero) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = (RED_STEPS > 0) ? ST_REDUCE : ST_READ;
                end
            end
            ST_REDUCE:
            begin
                cmd.red_en  = 1'b1;
                cmd.red_idx = red_cnt_reg;
                if (red_cnt_reg == '0) begin
                    state_next = lw_mode_reg ? ST_LWRITE : ST_READ;
                end else begin
                    red_cnt_next = red_cnt_reg - RED_CNT_W'(1);
                end
            end
            ST_READ:
            begin
                cmd.list_rd = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.rem_last ? ST_IDLE : ST_READ;
                end
            end
            ST_LWRITE:
            begin
                cmd.list_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `MPDFA_ASSERT_NEXT(a_scan_reads_desc, clk, rst_n, cmd.accept && action == ACT_SCAN, state_reg == ST_DESC, "scan request did not move on to the descriptor read")
    `MPDFA_ASSERT_NEXT(a_no_match_idle, clk, rst_n, state_reg == ST_PREP && sts.cnt_zero, state_reg == ST_IDLE, "byte without matches did not return to idle")
    `MPDFA_ASSERT_NEXT(a_emit_continues, clk, rst_n, cmd.emit && !sts.rem_last, state_reg == ST_READ, "match run ended before its last id")

endmodule

`default_nettype wire

### sv/mpdfa_dp.sv
`default_nettype none
`include "multi_pattern_dfa_matcher_core_defines.svh"

module mpdfa_dp #(
    parameter int STATE_COUNT   = 1024,
    parameter int LIST_DEPTH    = 4096,
    parameter int MAX_MATCHES   = 16,
    parameter int ID_BITS       = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mpdfa_pkg::in_item_t    item,
    input  mpdfa_pkg::dp_cmd_t     cmd,
    output mpdfa_pkg::dp_status_t  sts,
    output mpdfa_pkg::out_item_t   result,
    output logic                   result_valid,
    input  logic                   result_stall
);
    import mpdfa_pkg::*;

    localparam int SB = $clog2(STATE_COUNT);
    localparam int TB = SB + BYTE_W;
    localparam int LB = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int RW = (LB > LIST_FIELD_W) ? LB : LIST_FIELD_W;
    localparam int CW = $clog2(MAX_MATCHES + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [RW:0] DEPTH_W = (RW + 1)'(LIST_DEPTH);

    logic [STATE_FIELD_W-1:0] tbl_mem [STATE_COUNT * BYTE_SYMBOLS];
    desc_t                    desc_mem [STATE_COUNT];
    logic [ID_BITS-1:0]       list_mem [LIST_DEPTH];

    logic [SB-1:0]            scan_state_reg;
    logic [POSITION_BITS-1:0] scan_pos_reg;
    logic [POSITION_BITS-1:0] item_pos_reg;
    logic [STATE_FIELD_W-1:0] tbl_q_reg;
    desc_t                    desc_q_reg;
    logic [RW-1:0]            red_reg;
    logic [ID_BITS-1:0]       wdata_reg;
    logic [CW-1:0]            rem_reg;
    logic [ID_BITS-1:0]       list_q_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    logic                     is_scan, is_wr_trans, is_wr_desc, is_wr_list;
    logic                     sidx_ok;
    logic [SB-1:0]            start_state, nxt_state;
    logic [TB-1:0]            tbl_rd_addr, tbl_wr_addr;
    logic [POSITION_BITS-1:0] pos_cur;
    logic [CW-1:0]            cnt_clamp;
    logic [RW:0]              red_sub, red_inc;
    logic                     red_ge;
    logic [RW-1:0]            red_wrap;

    always_comb begin
        is_scan     = cmd.accept && (item.action == ACT_SCAN);
        is_wr_trans = cmd.accept && (item.action == ACT_WR_TRANS);
        is_wr_desc  = cmd.accept && (item.action == ACT_WR_DESC);
        is_wr_list  = cmd.accept && (item.action == ACT_WR_LIST);
        sidx_ok     = 32'(item.state_index) < 32'(STATE_COUNT);

        start_state = item.first_byte ? '0 : scan_state_reg;
        tbl_rd_addr = {start_state, item.byte_value};
        tbl_wr_addr = {SB'(item.state_index), item.byte_value};
        pos_cur     = item.first_byte ? '0 : scan_pos_reg;

        // A stored target outside the state range sends the scan back to the root.
        nxt_state = (32'(tbl_q_reg) >= 32'(STATE_COUNT)) ? '0 : SB'(tbl_q_reg);
        cnt_clamp = (32'(desc_q_reg.count) > 32'(MAX_MATCHES)) ?
                    CW'(MAX_MATCHES) : CW'(desc_q_reg.count);

        red_sub  = DEPTH_W << cmd.red_idx;
        red_ge   = {1'b0, red_reg} >= red_sub;
        red_inc  = {1'b0, red_reg} + (RW + 1)'(1);
        red_wrap = (red_inc == DEPTH_W) ? '0 : red_inc[RW-1:0];

        sts.cnt_zero = (cnt_clamp == '0);
        sts.rem_last = (rem_reg == CW'(1));
        sts.out_free = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk) begin
        if (is_wr_trans && sidx_ok) begin
            tbl_mem[tbl_wr_addr] <= item.target_state;
        end
        if (is_scan) begin
            tbl_q_reg <= tbl_mem[tbl_rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (is_wr_desc && sidx_ok) begin
            desc_mem[SB'(item.state_index)] <= '{count: item.match_count,
                                                 start: item.list_start};
        end
        if (cmd.desc_rd) begin
            desc_q_reg <= desc_mem[nxt_state];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.list_wr) begin
            list_mem[red_reg[LB-1:0]] <= wdata_reg;
        end
        if (cmd.list_rd) begin
            list_q_reg <= list_mem[red_reg[LB-1:0]];
        end
    end

    // The list pointer is reduced below the list depth by subtracting shifted
    // copies of the depth, then steps through the run with wraparound.
    always_ff @(posedge clk) begin
        if (is_wr_list) begin
            red_reg   <= RW'(item.list_index);
            wdata_reg <= ID_BITS'(item.pat_id);
        end else if (cmd.prep) begin
            red_reg <= RW'(desc_q_reg.start);
            rem_reg <= cnt_clamp;
        end else if (cmd.red_en) begin
            if (red_ge) begin
                red_reg <= red_reg - red_sub[RW-1:0];
            end
        end else if (cmd.emit) begin
            red_reg <= red_wrap;
            rem_reg <= rem_reg - CW'(1);
        end
        if (is_scan) begin
            item_pos_reg <= pos_cur;
        end
        if (cmd.emit) begin
            out_reg.found_pattern <= ID_FIELD_W'(list_q_reg);
            out_reg.byte_position <= POS_FIELD_W'(item_pos_reg);
            out_reg.last_match    <= sts.rem_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scan_state_reg <= '0;
            scan_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (is_scan) begin
                scan_pos_reg <= (pos_cur == POS_MAX) ? POS_MAX :
                                pos_cur + POSITION_BITS'(1);
            end
            if (cmd.desc_rd) begin
                scan_state_reg <= nxt_state;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (!result_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    `MPDFA_ASSERT_NEXT(a_emit_loads_out, clk, rst_n, cmd.emit, result_valid && result.last_match == $past(sts.rem_last), "emitted result not held with its last mark")
    `MPDFA_ASSERT_IMPL(a_list_ptr_range, clk, rst_n, cmd.list_rd || cmd.list_wr, {1'b0, red_reg} < DEPTH_W, "list pointer outside the list depth")
    `MPDFA_ASSERT_NEXT(a_rem_counts_down, clk, rst_n, cmd.emit && !sts.rem_last, rem_reg == $past(rem_reg) - CW'(1), "remaining match count did not step down")

endmodule

`default_nettype wire

### sv/multi_pattern_dfa_matcher_core.sv
// Multi-pattern byte scanner over a dense Aho-Corasick automaton built by the host.
// Input channel (item_valid / item_stall / item): one request per handshake. A scan
// request moves the automaton by one byte; write requests load the next-state
// table, the per-state match descriptors or the pattern id list.
// Output channel (result_valid / result_stall / result): one result per pattern id
// listed for the state reached by a scanned byte (at most MAX_MATCHES), in list
// order, with the byte position and a last mark on the final id of the byte.
// A table or descriptor write completes in the accept cycle; a list write then
// passes through the list write state. A scan reads the next-state table at
// acceptance, then the descriptor, then loads the id run; with matches it then
// does one list memory read and one result emission per id.
// When the list depth does not cover every 12-bit index, each list write and
// each matching scan first runs through the index reduction steps.
// A stalled result waits in the output register; the core keeps working and the
// next id waits until that register is free. New requests are taken while the
// last result of a byte still waits.
// Reset returns the scan to the root state and position zero; the tables are
// not cleared and must be written before they are used.
`default_nettype none

module multi_pattern_dfa_matcher_core #(
    parameter int STATE_COUNT   = 1024,
    parameter int LIST_DEPTH    = 4096,
    parameter int MAX_MATCHES   = 16,
    parameter int ID_BITS       = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  mpdfa_pkg::in_item_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output mpdfa_pkg::out_item_t  result
);
    import mpdfa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    mpdfa_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .action     (item.action),
        .sts        (sts),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    mpdfa_dp #(
        .STATE_COUNT   (STATE_COUNT),
        .LIST_DEPTH    (LIST_DEPTH),
        .MAX_MATCHES   (MAX_MATCHES),
        .ID_BITS       (ID_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire

### tb/dfa_match_checker.sv
module dfa_match_checker #(
    parameter int STATE_COUNT   = 1024,
    parameter int LIST_DEPTH    = 4096,
    parameter int MAX_MATCHES   = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 item_stall,
    input  mpdfa_pkg::in_item_t  item,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  mpdfa_pkg::out_item_t result,
    input  logic                 drain_done,
    output int                   mismatch_count,
    output int                   matches_pending
);
    import mpdfa_pkg::*;

    localparam longint POS_MAX = (longint'(1) << POSITION_BITS) - 1;

    // Shadow copies of the automaton tables and the scan registers.
    bit [STATE_FIELD_W-1:0] trans_mem [int];
    bit [COUNT_FIELD_W-1:0] desc_count [STATE_COUNT];
    bit [LIST_FIELD_W-1:0]  desc_start [STATE_COUNT];
    bit [ID_FIELD_W-1:0]    id_list [LIST_DEPTH];
    int unsigned            scan_state;
    longint                 scan_pos;
    out_item_t              expected_matches [$];
    bit                     leftovers_checked;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic predict_matches(input in_item_t req);
        int unsigned from;
        int unsigned to;
        int unsigned hits;
        int          key;
        longint      pos;
        out_item_t   hit_item;
        case (req.action)
            ACT_WR_TRANS:
            begin
                if (req.state_index < STATE_COUNT)
                begin
                    trans_mem[req.state_index * BYTE_SYMBOLS + req.byte_value] = req.target_state;
                end
            end
            ACT_WR_DESC:
            begin
                if (req.state_index < STATE_COUNT)
                begin
                    desc_count[req.state_index] = req.match_count;
                    desc_start[req.state_index] = req.list_start;
                end
            end
            ACT_WR_LIST:
            begin
                id_list[req.list_index % LIST_DEPTH] = req.pat_id;
            end
            ACT_SCAN:
            begin
                if (req.first_byte)
                begin
                    scan_state = 0;
                    scan_pos   = 0;
                end
                from = (scan_state < STATE_COUNT) ? scan_state : 0;
                key  = int'(from * BYTE_SYMBOLS + req.byte_value);
                to   = trans_mem.exists(key) ? trans_mem[key] : 0;
                if (to >= STATE_COUNT)
                begin
                    to = 0;
                end
                scan_state = to;
                pos = (scan_pos > POS_MAX) ? POS_MAX : scan_pos;
                scan_pos = (pos < POS_MAX) ? pos + 1 : POS_MAX;
                hits = (desc_count[to] > MAX_MATCHES) ? MAX_MATCHES : desc_count[to];
                for (int k = 0; k < hits; k++)
                begin
                    hit_item.found_pattern = id_list[(desc_start[to] + k) % LIST_DEPTH];
                    hit_item.byte_position = pos[POS_FIELD_W-1:0];
                    hit_item.last_match    = (k == hits - 1);
                    expected_matches.push_back(hit_item);
                end
            end
        endcase
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_matches.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result: id %0d position %0d last %0b",
                got.found_pattern, got.byte_position, got.last_match));
            return;
        end
        want = expected_matches.pop_front();
        if (got.found_pattern !== want.found_pattern)
        begin
            report_mismatch($sformatf("found_pattern %0d, expected %0d",
                got.found_pattern, want.found_pattern));
        end
        if (got.byte_position !== want.byte_position)
        begin
            report_mismatch($sformatf("byte_position %0d, expected %0d",
                got.byte_position, want.byte_position));
        end
        if (got.last_match !== want.last_match)
        begin
            report_mismatch($sformatf("last_match %0b, expected %0b (id %0d)",
                got.last_match, want.last_match, want.found_pattern));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state = 0;
            scan_pos   = 0;
            expected_matches.delete();
            mismatch_count    = 0;
            leftovers_checked = 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                check_result(result);
            end
            if (item_valid && !item_stall)
            begin
                predict_matches(item);
            end
            if (drain_done && !leftovers_checked)
            begin
                leftovers_checked = 1'b1;
                if (expected_matches.size() != 0)
                begin
                    report_mismatch($sformatf("%0d expected results never arrived",
                        expected_matches.size()));
                end
            end
        end
        matches_pending <= expected_matches.size();
    end

endmodule

### tb/testbench.sv
module testbench;
    import mpdfa_pkg::*;

    localparam int STATE_COUNT = 1024;
    localparam int LIST_DEPTH  = 4096;
    localparam int MAX_IDS     = 16;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;
    logic      drain_done;
    int        mismatch_count;
    int        matches_pending;

    // Transitions written so far, so that every scanned byte follows a written entry.
    bit [STATE_FIELD_W-1:0] written_trans [int];
    int unsigned            walk_state;
    int                     burst_left;
    int                     requests_sent;

    multi_pattern_dfa_matcher_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    dfa_match_checker match_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .drain_done      (drain_done),
        .mismatch_count  (mismatch_count),
        .matches_pending (matches_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        stall_mode_t mode;
        int          span;
        result_stall <= 1'b0;
        forever
        begin
            mode = stall_mode_t'($urandom_range(0, 2));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE:  result_stall <= 1'b0;
                    STALL_LIGHT: result_stall <= ($urandom_range(0, 2) == 0);
                    default:     result_stall <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    function automatic in_item_t random_request();
        in_item_t req;
        req.action       = action_t'($urandom_range(0, 3));
        req.byte_value   = BYTE_W'($urandom_range(0, 255));
        req.first_byte   = 1'($urandom_range(0, 1));
        req.state_index  = STATE_FIELD_W'($urandom_range(0, STATE_COUNT - 1));
        req.target_state = STATE_FIELD_W'($urandom_range(0, STATE_COUNT - 1));
        req.match_count  = COUNT_FIELD_W'($urandom_range(0, 31));
        req.list_start   = LIST_FIELD_W'($urandom_range(0, 4095));
        req.list_index   = LIST_FIELD_W'($urandom_range(0, 4095));
        req.pat_id       = ID_FIELD_W'($urandom_range(0, 65535));
        return req;
    endfunction

    // Sends one request; the sender works in bursts with random gaps between them.
    task automatic send_request(input in_item_t req);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        item       <= req;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        requests_sent++;
    endtask

    task automatic write_trans(input int unsigned from, input int unsigned sym,
                               input int unsigned to);
        in_item_t req;
        req = random_request();
        req.action       = ACT_WR_TRANS;
        req.state_index  = STATE_FIELD_W'(from);
        req.byte_value   = BYTE_W'(sym);
        req.target_state = STATE_FIELD_W'(to);
        written_trans[from * BYTE_SYMBOLS + sym] = STATE_FIELD_W'(to);
        send_request(req);
    endtask

    task automatic write_desc(input int unsigned state, input int unsigned count,
                              input int unsigned start);
        in_item_t req;
        req = random_request();
        req.action      = ACT_WR_DESC;
        req.state_index = STATE_FIELD_W'(state);
        req.match_count = COUNT_FIELD_W'(count);
        req.list_start  = LIST_FIELD_W'(start);
        send_request(req);
    endtask

    task automatic write_list(input int unsigned slot, input int unsigned id);
        in_item_t req;
        req = random_request();
        req.action     = ACT_WR_LIST;
        req.list_index = LIST_FIELD_W'(slot);
        req.pat_id     = ID_FIELD_W'(id);
        send_request(req);
    endtask

    task automatic scan_byte(input int unsigned sym, input bit first);
        in_item_t req;
        req = random_request();
        req.action     = ACT_SCAN;
        req.byte_value = BYTE_W'(sym);
        req.first_byte = first;
        if (first)
        begin
            walk_state = 0;
        end
        walk_state = written_trans[walk_state * BYTE_SYMBOLS + sym];
        send_request(req);
    endtask

    // Root without ids, and a top state whose id run is capped and wraps past the list end.
    task automatic run_directed();
        write_desc(0, 0, 0);
        write_desc(STATE_COUNT - 1, 17, LIST_DEPTH - 8);
        for (int k = 0; k < MAX_IDS; k++)
        begin
            write_list((LIST_DEPTH - 8 + k) % LIST_DEPTH,
                (k == 0) ? 16'hFFFF : (k == MAX_IDS - 1) ? 0 : $urandom_range(0, 65535));
        end
        write_trans(0, 8'h00, STATE_COUNT - 1);
        write_trans(0, 8'hFF, 0);
        write_trans(STATE_COUNT - 1, 8'hFF, 0);
        write_trans(STATE_COUNT - 1, 8'h00, STATE_COUNT - 1);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b1);
    endtask

    // Loads a small automaton and scans one text over its alphabet. The current
    // state and the root are always part of it, so a text may also run on without
    // a restart. Stray writes go first and are overwritten where they would matter.
    task automatic load_and_scan_text();
        int unsigned members [$];
        int unsigned symbols [$];
        in_item_t    req;
        int unsigned count;
        int unsigned start;
        int          n;
        int          len;
        bit          restart;
        repeat ($urandom_range(0, 3))
        begin
            req = random_request();
            if (req.action == ACT_SCAN)
            begin
                req.action = ACT_WR_LIST;
            end
            if (req.action == ACT_WR_TRANS)
            begin
                written_trans[req.state_index * BYTE_SYMBOLS + req.byte_value] =
                    req.target_state;
            end
            send_request(req);
        end
        members.push_back(0);
        if (walk_state != 0)
        begin
            members.push_back(walk_state);
        end
        n = $urandom_range(2, 5);
        while (members.size() < n)
        begin
            members.push_back($urandom_range(1, STATE_COUNT - 1));
        end
        repeat ($urandom_range(1, 4))
        begin
            symbols.push_back($urandom_range(0, 255));
        end
        foreach (members[i])
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: count = 0;
                9:       count = $urandom_range(16, 31);
                default: count = $urandom_range(1, 4);
            endcase
            start = ($urandom_range(0, 3) == 0) ? $urandom_range(LIST_DEPTH - 16, LIST_DEPTH - 1)
                                                : $urandom_range(0, LIST_DEPTH - 1);
            write_desc(members[i], count, start);
            for (int k = 0; k < count && k < MAX_IDS; k++)
            begin
                write_list((start + k) % LIST_DEPTH, $urandom_range(0, 65535));
            end
        end
        foreach (members[i])
        begin
            foreach (symbols[j])
            begin
                write_trans(members[i], symbols[j], members[$urandom_range(0, members.size() - 1)]);
            end
        end
        restart = ($urandom_range(0, 4) != 0);
        len = $urandom_range(4, 24);
        for (int i = 0; i < len; i++)
        begin
            scan_byte(symbols[$urandom_range(0, symbols.size() - 1)],
                (i == 0) ? restart : ($urandom_range(0, 29) == 0));
        end
    endtask

    initial
    begin
        int random_base;
        int waited;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        drain_done   <= 1'b0;
        walk_state    = 0;
        burst_left    = 0;
        requests_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        random_base = requests_sent;
        while (requests_sent - random_base < 220)
        begin
            load_and_scan_text();
        end
        item_valid <= 1'b0;

        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (matches_pending != 0 && waited < 20000);
        repeat (40) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
